FILE: sv/levenshtein_automaton_matcher_defines.svh
// Assertion macros used by the checker file.
`ifndef LEVENSHTEIN_AUTOMATON_MATCHER_DEFINES_SVH
`define LEVENSHTEIN_AUTOMATON_MATCHER_DEFINES_SVH

// Clocked property, switched off while reset is high.
`define LAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define LAM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/lam_pkg.sv
`default_nettype none
package lam_pkg;

  localparam int MAX_PATTERN  = 16;
  localparam int MAX_DIST     = 3;
  localparam int STORED_CHARS = 16;

  // Positions actually usable: bounded by the characters stored.
  localparam int EFF_MAX = (MAX_PATTERN < STORED_CHARS) ? MAX_PATTERN : STORED_CHARS;
  localparam int POS_W   = EFF_MAX + 1;
  localparam int ROWS    = MAX_DIST + 1;
  localparam int N_W     = $clog2(EFF_MAX + 1);
  localparam int K_W     = (MAX_DIST > 0) ? $clog2(MAX_DIST + 1) : 1;

  localparam int LEN_W     = 5;
  localparam int DIST_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;
  localparam int OUT_W     = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 4'd0,
    REG_PATTERN_HIGH = 4'd1,
    REG_PATTERN_LEN  = 4'd2,
    REG_MAX_DIST     = 4'd3
  } cfg_reg_t;

  // Effective pattern length and error bound, already saturated.
  typedef struct packed {
    logic [N_W-1:0] n;
    logic [K_W-1:0] k;
  } lam_cfg_t;

  // Classified word: position match vector and restart flag.
  typedef struct packed {
    logic [EFF_MAX-1:0] match;
    logic               first;
  } lam_item_t;

endpackage
`default_nettype wire

FILE: sv/lam_front.sv
`default_nettype none
module lam_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lam_pkg::CFG_W-1:0]     cfg_data,
  input  logic [lam_pkg::CHAR_W-1:0]    ch,
  input  logic                          first,
  output lam_pkg::lam_item_t            item,
  output lam_pkg::lam_cfg_t             cfg
);
  import lam_pkg::*;

  logic [CFG_W-1:0]  pattern_low;
  logic [CFG_W-1:0]  pattern_high;
  logic [LEN_W-1:0]  pattern_length;
  logic [DIST_W-1:0] max_distance;
  logic [2*CFG_W-1:0] pattern_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      max_distance   <= DIST_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        REG_MAX_DIST:     max_distance   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate length to the stored characters and the bound to the rows built.
  assign cfg.n = (pattern_length > LEN_W'(EFF_MAX)) ? N_W'(EFF_MAX) : N_W'(pattern_length);
  assign cfg.k = (32'(max_distance) > MAX_DIST) ? K_W'(MAX_DIST) : K_W'(max_distance);

  assign pattern_bytes = {pattern_high, pattern_low};

  always_comb begin
    for (int i = 0; i < EFF_MAX; i++) begin
      item.match[i] = (i < 32'(cfg.n)) && (pattern_bytes[i*CHAR_W +: CHAR_W] == ch);
    end
    item.first = first;
  end

endmodule
`default_nettype wire

FILE: sv/lam_queue.sv
`default_nettype none
module lam_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lam_pkg::lam_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               nonempty,
  output lam_pkg::lam_item_t pop_item
);
  import lam_pkg::*;

  lam_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop && nonempty) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push && !full, pop && nonempty})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/lam_back.sv
`default_nettype none
module lam_back (
  input  logic                        clk,
  input  logic                        rst,
  input  lam_pkg::lam_cfg_t           cfg,
  input  logic                        q_nonempty,
  input  lam_pkg::lam_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lam_pkg::OUT_W-1:0]   out_data
);
  import lam_pkg::*;

  logic [POS_W-1:0] state      [ROWS];
  logic [POS_W-1:0] state_next [ROWS];
  logic [POS_W-1:0] base       [ROWS];
  logic [POS_W-1:0] old        [ROWS];
  logic [POS_W-1:0] mask;
  logic [POS_W-1:0] match_ext;
  logic              accept_next;
  logic [DIST_W-1:0] distance_next;
  logic              alive_next;
  logic              accept;
  logic [DIST_W-1:0] distance;
  logic              alive;

  assign q_pop     = q_nonempty && (!out_valid || out_ready);
  assign match_ext = {1'b0, q_item.match};

  always_comb begin
    for (int i = 0; i < POS_W; i++) begin
      mask[i] = (i <= 32'(cfg.n));
    end
    for (int e = 0; e < ROWS; e++) begin
      if (q_item.first) begin
        base[e] = ((e <= 32'(cfg.k)) && (e <= 32'(cfg.n))) ? (POS_W'(1) << e) : '0;
      end else begin
        base[e] = state[e];
      end
      old[e] = (e <= 32'(cfg.k)) ? (base[e] & mask) : '0;
    end
    // Match, insertion and substitution moves.
    for (int e = 0; e < ROWS; e++) begin
      state_next[e] = '0;
      if (e <= 32'(cfg.k)) begin
        state_next[e] = (old[e] & match_ext) << 1;
        if (e > 0) begin
          state_next[e] = state_next[e] | old[e-1] | (old[e-1] << 1);
        end
        state_next[e] = state_next[e] & mask;
      end
    end
    // Deletion closure runs down the rows in order.
    for (int e = 1; e < ROWS; e++) begin
      if (e <= 32'(cfg.k)) begin
        state_next[e] = state_next[e] | ((state_next[e-1] << 1) & mask);
      end
    end
    accept_next   = 1'b0;
    distance_next = '0;
    alive_next    = 1'b0;
    for (int e = ROWS - 1; e >= 0; e--) begin
      if (state_next[e][cfg.n]) begin
        accept_next   = 1'b1;
        distance_next = DIST_W'(e);
      end
      alive_next = alive_next | (|state_next[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < ROWS; e++) begin
        state[e] <= (e == 0) ? POS_W'(1) : '0;
      end
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      accept   <= accept_next;
      distance <= distance_next;
      alive    <= alive_next;
    end
  end

  assign out_data = {(OUT_W - DIST_W - 2)'(0), alive, distance, accept};

endmodule
`default_nettype wire

FILE: sv/levenshtein_automaton_matcher.sv
// Levenshtein automaton matcher: streams word characters through an NFA
// for the configured pattern and error bound.
// Config channel: cfg_index selects pattern_low_chars (0), pattern_high_chars
// (1), pattern_length (2) or max_distance (3); cfg_ready is always high and
// other indexes are ignored. Write only while no word is in flight.
// Input word: tdata = ch, tuser = first (restart from the closed initial
// state before consuming ch). Output word: accept, distance, alive.
// Path: an input word accepted on s_axis is registered in the queue, and its
// result is registered in the back end before it shows on m_axis. Throughput:
// one word per cycle while m_axis_tready stays high, as the back end updates
// the state once per popped word (each word needs the state the previous one left).
// A two-entry queue sits between the classifier and the state update, and
// the result register holds while m_axis_tready is low; s_axis_tready drops
// only once the queue is full.
// Reset clears the registers to their defaults (max_distance 1, everything
// else 0), empties the queue and loads state (0,0) only.
`default_nettype none
module levenshtein_automaton_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lam_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lam_pkg::CHAR_W-1:0]    s_axis_tdata,   // [7:0] ch
  input  logic                          s_axis_tuser,   // [0] first
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lam_pkg::OUT_W-1:0]     m_axis_tdata    // [0] accept, [2:1] distance, [3] alive
);
  import lam_pkg::*;

  lam_item_t front_item;
  lam_item_t q_item;
  lam_cfg_t  cfg;
  logic      q_full;
  logic      q_nonempty;
  logic      q_pop;

  assign s_axis_tready = !q_full;

  lam_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ch        (s_axis_tdata),
    .first     (s_axis_tuser),
    .item      (front_item),
    .cfg       (cfg)
  );

  lam_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (q_item)
  );

  lam_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule
`default_nettype wire

FILE: sv/lam_checker.sv
`default_nettype none
`include "levenshtein_automaton_matcher_defines.svh"
module lam_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lam_pkg::OUT_W-1:0]     m_axis_tdata
);
  import lam_pkg::*;

  `LAM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
  `LAM_ASSERT(a_dist_needs_accept, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'd0, "distance set without accept")
  `LAM_ASSERT(a_accept_alive, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3], "accept without any live state")
  `LAM_NEVER(a_pad_zero, m_axis_tvalid && (m_axis_tdata[OUT_W-1:4] != '0), "padding bits not zero")
  `LAM_ASSERT(a_reset_empty, $past(rst) |-> !m_axis_tvalid, "result word right after reset")

endmodule

bind levenshtein_automaton_matcher lam_checker u_lam_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lam_pkg::*;

  // Result word as laid out on m_axis_tdata, lowest bit last.
  typedef struct packed {
    logic [3:0]        pad;
    logic              alive;
    logic [DIST_W-1:0] distance;
    logic              accept;
  } match_word_t;

  typedef enum logic {ROW_WRITE, ROW_CHAR} row_kind_t;
  typedef enum int {EDIT_SUB, EDIT_DEL, EDIT_INS} edit_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    logic [CHAR_W-1:0]      ch;
    logic                   first;
    logic                   typed;
    match_word_t            want;
  } dir_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  localparam match_word_t DEAD     = '{4'h0, 1'b0, 2'd0, 1'b0};
  localparam match_word_t EMPTY_K1 = '{4'h0, 1'b1, 2'd1, 1'b1};
  localparam match_word_t EXACT0   = '{4'h0, 1'b1, 2'd0, 1'b1};

  // idx and data only matter on write rows, ch and first only on char rows.
  dir_row_t opening_rows [35] = '{
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h00, 1'b0, 1'b1, EMPTY_K1},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'hFF, 1'b0, 1'b1, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h41, 1'b1, 1'b1, EMPTY_K1},
    '{ROW_WRITE, REG_PATTERN_LOW,  64'h6867_6665_6463_6261, 8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_PATTERN_HIGH, 64'h00FF_6E6D_6C6B_6A69, 8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_PATTERN_LEN,  64'd16,                 8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_MAX_DIST,     64'd3,                  8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h61, 1'b1, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h62, 1'b0, 1'b0, DEAD},
    // narrow the bound mid-string: upper rows are dropped, the rest kept
    '{ROW_WRITE, REG_MAX_DIST,     64'd0,                  8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h63, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h78, 1'b0, 1'b1, DEAD},
    // oversized length saturates to the stored characters
    '{ROW_WRITE, REG_PATTERN_LEN,  64'd31,                 8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_MAX_DIST,     64'd3,                  8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h61, 1'b1, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h62, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h63, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h64, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h65, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h66, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h67, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h68, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h69, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h6A, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h6B, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h6C, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h6D, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_SPARE,        '1,                     8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_PATTERN_LOW,  64'h0000_0000_0000_00FF, 8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_PATTERN_LEN,  64'd2,                  8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_WRITE, REG_MAX_DIST,     64'd0,                  8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'hFF, 1'b1, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h00, 1'b0, 1'b1, EXACT0},
    // empty pattern with no insertions allowed: nothing survives a character
    '{ROW_WRITE, REG_PATTERN_LEN,  64'd0,                  8'h00, 1'b0, 1'b0, DEAD},
    '{ROW_CHAR,  REG_SPARE,        64'h0,                  8'h7A, 1'b1, 1'b1, DEAD}
  };

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [CHAR_W-1:0]    s_axis_tdata  = '0;   // [7:0] ch
  logic                 s_axis_tuser  = 1'b0; // [0] first
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;         // [0] accept, [2:1] distance, [3] alive

  levenshtein_automaton_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow registers and automaton state.
  logic [CFG_W-1:0]  pat_lo;
  logic [CFG_W-1:0]  pat_hi;
  logic [LEN_W-1:0]  pat_len;
  logic [DIST_W-1:0] max_dist;
  logic [POS_W-1:0]  nfa_rows [ROWS];

  match_word_t pending_words [$];
  int          mismatches   = 0;
  int          items_sent   = 0;
  bit          calm         = 1'b0;
  bit          narrow_alpha = 1'b1;
  bit          pressure_req = 1'b0;
  bit          pressure_done = 1'b0;
  int          hold_left    = 0;

  function automatic int eff_len();
    return (pat_len > EFF_MAX) ? EFF_MAX : int'(pat_len);
  endfunction

  function automatic int eff_bound();
    return (max_dist > MAX_DIST) ? MAX_DIST : int'(max_dist);
  endfunction

  function automatic logic [CHAR_W-1:0] pat_char(input int i);
    return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    return narrow_alpha ? 8'($urandom_range(8'h61, 8'h64)) : 8'($urandom_range(0, 255));
  endfunction

  // Closed initial state: (0,0) plus its deletion chain (j,j).
  function automatic void load_start();
    int e;
    for (e = 0; e < ROWS; e++)
      nfa_rows[e] = (e <= eff_bound() && e <= eff_len()) ? POS_W'(1) << e : '0;
  endfunction

  function automatic match_word_t advance_nfa(input logic [CHAR_W-1:0] ch, input logic first);
    int               n;
    int               k;
    int               i;
    int               e;
    logic [POS_W-1:0] mask;
    logic [POS_W-1:0] hits;
    logic [POS_W-1:0] prev [ROWS];
    logic [POS_W-1:0] nxt [ROWS];
    match_word_t      w;
    n = eff_len();
    k = eff_bound();
    if (first)
      load_start();
    mask = '0;
    for (i = 0; i <= n; i++)
      mask[i] = 1'b1;
    hits = '0;
    for (i = 0; i < n; i++)
      if (pat_char(i) == ch)
        hits[i] = 1'b1;
    for (e = 0; e < ROWS; e++)
      prev[e] = (e <= k) ? (nfa_rows[e] & mask) : '0;
    for (e = 0; e < ROWS; e++) begin
      nxt[e] = '0;
      if (e <= k) begin
        nxt[e] = (prev[e] & hits) << 1;
        if (e > 0)
          nxt[e] |= prev[e-1] | (prev[e-1] << 1);
        nxt[e] &= mask;
      end
    end
    // deletion closure, row by row upwards
    for (e = 1; e <= k; e++)
      nxt[e] |= (nxt[e-1] << 1) & mask;
    w = '0;
    for (e = 0; e < ROWS; e++) begin
      nfa_rows[e] = nxt[e];
      if (nxt[e] != '0)
        w.alive = 1'b1;
      if (!w.accept && nxt[e][n]) begin
        w.accept   = 1'b1;
        w.distance = DIST_W'(e);
      end
    end
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LOW:  pat_lo   = data;
      REG_PATTERN_HIGH: pat_hi   = data;
      REG_PATTERN_LEN:  pat_len  = data[LEN_W-1:0];
      REG_MAX_DIST:     max_dist = data[DIST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic offer_char(input logic [CHAR_W-1:0] ch, input logic first,
                            input logic typed, input match_word_t want);
    match_word_t pred;
    while (!calm && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= first;
    do @(posedge clk); while (!s_axis_tready);
    pred = advance_nfa(ch, first);
    pending_words.insert(pending_words.size(), typed ? want : pred);
    items_sent++;
    calm = (items_sent >= 700 && items_sent < 1000);
    if (items_sent >= 1200)
      pressure_req = 1'b1;
    @(negedge clk);
  endtask

  // Hold the input low until every expected word is back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic flag_error(input string what, input match_word_t want, input match_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected accept=%0b distance=%0d alive=%0b pad=%h, ",
               $time, what, want.accept, want.distance, want.alive, want.pad,
               "got accept=%0b distance=%0d alive=%0b pad=%h",
               got.accept, got.distance, got.alive, got.pad);
  endtask

  always @(posedge clk) begin : result_check
    match_word_t got;
    match_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = match_word_t'(m_axis_tdata);
      if (pending_words.size() == 0) begin
        flag_error("unexpected word", '0, got);
      end else begin
        want = pending_words.pop_front();
        if (got.accept !== want.accept)
          flag_error("accept", want, got);
        if (got.distance !== want.distance)
          flag_error("distance", want, got);
        if (got.alive !== want.alive)
          flag_error("alive", want, got);
        if (got.pad !== want.pad)
          flag_error("padding", want, got);
      end
    end
  end

  // Sink side: random back-pressure, one long hold to fill the block up.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (pressure_req && !pressure_done) begin
      hold_left     <= 120;
      pressure_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
    end
  end

  initial begin
    #5_000_000;
    $display("levenshtein_automaton_matcher test failed");
    $finish;
  end

  initial begin
    bit                writing;
    int                i;
    int                j;
    int                b;
    int                r;
    int                n_pick;
    int                budget;
    int                nterms;
    int                len;
    logic [CFG_W-1:0]  chunk;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] term_q [$];

    pat_lo   = '0;
    pat_hi   = '0;
    pat_len  = '0;
    max_dist = DIST_W'(1);
    load_start();
    writing = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(opening_rows); i++) begin
      if (opening_rows[i].kind == ROW_WRITE) begin
        if (!writing)
          drain_results();
        write_reg(opening_rows[i].idx, opening_rows[i].data);
        writing = 1'b1;
      end else begin
        if (writing)
          end_writes();
        writing = 1'b0;
        offer_char(opening_rows[i].ch, opening_rows[i].first,
                   opening_rows[i].typed, opening_rows[i].want);
      end
    end

    while (items_sent < 1800) begin
      drain_results();
      narrow_alpha = ($urandom_range(0, 99) < 60);
      if ($urandom_range(0, 99) < 80) begin
        for (b = 0; b < 8; b++)
          chunk[8*b +: 8] = rand_char();
        write_reg(REG_PATTERN_LOW, chunk);
      end
      if ($urandom_range(0, 99) < 80) begin
        for (b = 0; b < 8; b++)
          chunk[8*b +: 8] = rand_char();
        write_reg(REG_PATTERN_HIGH, chunk);
      end
      if ($urandom_range(0, 99) < 80) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          n_pick = 0;
        else if (r < 18)
          n_pick = EFF_MAX;
        else if (r < 26)
          n_pick = $urandom_range(EFF_MAX + 1, (1 << LEN_W) - 1);
        else
          n_pick = $urandom_range(1, EFF_MAX - 1);
        chunk = {$urandom, $urandom};
        chunk[LEN_W-1:0] = n_pick[LEN_W-1:0];
        write_reg(REG_PATTERN_LEN, chunk);
      end
      if ($urandom_range(0, 99) < 80)
        write_reg(REG_MAX_DIST, {$urandom, $urandom});
      if ($urandom_range(0, 99) < 5)
        write_reg(CFG_IDX_W'($urandom_range(REG_MAX_DIST + 1, REG_SPARE)), {$urandom, $urandom});
      end_writes();

      nterms = $urandom_range(2, 8);
      repeat (nterms) begin
        if ($urandom_range(0, 99) < 85) begin
          // pattern with a few random edits, started from the initial state
          term_q.delete();
          budget = $urandom_range(0, eff_bound() + 1);
          for (j = 0; j < eff_len(); j++) begin
            c = pat_char(j);
            if (budget > 0 && $urandom_range(0, 99) < 30) begin
              budget--;
              case (edit_t'($urandom_range(EDIT_SUB, EDIT_INS)))
                EDIT_SUB: term_q.insert(term_q.size(), rand_char());
                EDIT_DEL: ;
                default: begin
                  term_q.insert(term_q.size(), rand_char());
                  term_q.insert(term_q.size(), c);
                end
              endcase
            end else begin
              term_q.insert(term_q.size(), c);
            end
          end
          while (budget > 0 && $urandom_range(0, 1) == 1) begin
            term_q.insert(term_q.size(), rand_char());
            budget--;
          end
          if (term_q.size() == 0)
            term_q.insert(term_q.size(), rand_char());
          for (j = 0; j < term_q.size(); j++)
            offer_char(term_q[j], j == 0, 1'b0, DEAD);
        end else begin
          // noise: random characters with stray restarts
          len = $urandom_range(1, 6);
          repeat (len)
            offer_char(rand_char(), $urandom_range(0, 99) < 20, 1'b0, DEAD);
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("levenshtein_automaton_matcher test passed");
    else
      $display("levenshtein_automaton_matcher test failed");
    $finish;
  end

endmodule
